>>> design/swsp_pkg.sv
// Shared constants, result region codes and log table generator for the
// surface wind scaling pipeline. No dependencies.
`default_nettype none

package swsp_pkg;

   // Default log table index width (table holds 2**bits entries)
   localparam int unsigned LOG_TABLE_BITS_DEF = 10;

   // ln(2) in Q16 and 1.0 in Q2.14
   localparam logic [15:0] LN2_Q16 = 16'd45426;
   localparam logic [15:0] ONE_Q14 = 16'd16384;

   // Reset value of the height coefficient, Q0.16
   localparam logic [15:0] COEF_RESET = 16'd22390;

   // Register stages of one log unit
   localparam int unsigned LOG_LAT = 4;

   // Widths of the two dividers
   localparam int unsigned DX_DEN_W  = 15;
   localparam int unsigned DX_QUO_W  = 22;
   localparam int unsigned INT_DEN_W = 20;
   localparam int unsigned INT_QUO_W = 16;

   typedef enum logic [1:0] {
      REGION_MISSING = 2'd0,
      REGION_ABOVE   = 2'd1,
      REGION_INTERP  = 2'd2,
      REGION_BELOW   = 2'd3
   } region_type;

   // Restoring divide, used only while building constant tables
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] rem;
      logic [63:0] q;
      rem = '0;
      q   = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], n[i]};
         if (rem >= {1'b0, d}) begin
            rem  = rem - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // ln(1 + idx/2**bits) in Q16, rounded, by an atanh series in Q32
   function automatic logic [15:0] log_entry(input int unsigned idx, input int unsigned bits);
      logic [63:0] den;
      logic [63:0] z;
      logic [63:0] z2;
      logic [63:0] term;
      logic [63:0] sum;
      den  = (64'd2 << bits) + 64'(idx);
      z    = udiv64(64'(idx) << 32, den);
      z2   = (z * z) >> 32;
      term = z;
      sum  = '0;
      for (int k = 0; k < 24; k++) begin
         sum  = sum + udiv64(term, 64'(2 * k + 1));
         term = (term * z2) >> 32;
      end
      return 16'((64'd2 * sum + 64'd32768) >> 16);
   endfunction

endpackage

`default_nettype wire

>>> design/swsp_log.sv
// Pipelined natural log of a 17-bit pressure, Q4.16 result, four stages.
// Uses swsp_pkg for the table generator and ln(2).
`default_nettype none

module swsp_log #(
   parameter int unsigned TABLE_BITS = swsp_pkg::LOG_TABLE_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        adv,
   input  wire logic [16:0] x,
   output logic      [19:0] ln
);

   localparam int unsigned DEPTH = 1 << TABLE_BITS;

   logic [15:0] rom_w [DEPTH];

   // Build the mantissa table at elaboration
   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_rom
      localparam logic [15:0] ENTRY = swsp_pkg::log_entry(gi, TABLE_BITS);
      assign rom_w[gi] = ENTRY;
   end

   function automatic logic [4:0] lead_one(input logic [16:0] v);
      logic [4:0] e;
      e = '0;
      for (int i = 0; i < 17; i++) begin
         if (v[i]) e = 5'(i);
      end
      return e;
   endfunction

   logic [16:0]           x_fix;
   logic [16:0]           x1_ff;
   logic [4:0]            e1_ff;
   logic [16:0]           xn;
   logic [TABLE_BITS-1:0] addr2_ff;
   logic [4:0]            e2_ff;
   logic [15:0]           tab3_ff;
   logic [4:0]            e3_ff;
   logic [20:0]           ln_in;
   logic [19:0]           ln_ff;

   // Treat zero pressure as one pascal
   assign x_fix = (x == 17'd0) ? 17'd1 : x;
   // Align the leading one to the top bit
   assign xn    = x1_ff << (5'd16 - e1_ff);
   assign ln_in = 21'(e3_ff) * 21'(swsp_pkg::LN2_Q16) + 21'(tab3_ff);

   // Exponent, index, table read, combine
   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff    <= x_fix;
         e1_ff    <= lead_one(x_fix);
         addr2_ff <= xn[15 -: TABLE_BITS];
         e2_ff    <= e1_ff;
         tab3_ff  <= rom_w[addr2_ff];
         e3_ff    <= e2_ff;
         ln_ff    <= ln_in[19:0];
      end
   end

   assign ln = ln_ff;

endmodule

`default_nettype wire

>>> design/swsp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
// Uses no package items.
`default_nettype none

module swsp_div #(
   parameter int unsigned DW = 15,
   parameter int unsigned QW = 22,
   parameter int unsigned PW = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire logic             in_valid,
   input  wire logic [DW+QW-1:0] in_num,
   input  wire logic [DW-1:0]    in_den,
   input  wire logic [PW-1:0]    in_side,
   output logic                  out_valid,
   output logic      [QW-1:0]    out_quo,
   output logic      [PW-1:0]    out_side
);

   localparam int unsigned RW = DW + QW;

   logic [RW-1:0] st_rem  [QW+1];
   logic [DW-1:0] st_den  [QW+1];
   logic [QW-1:0] st_quo  [QW+1];
   logic [PW-1:0] st_side [QW+1];
   logic          st_vld  [QW+1];

   assign st_rem[0]  = in_num;
   assign st_den[0]  = in_den;
   assign st_quo[0]  = '0;
   assign st_side[0] = in_side;
   assign st_vld[0]  = in_valid;

   for (genvar gi = 0; gi < QW; gi++) begin : g_stage
      logic [RW-1:0] dsh;
      logic          ge;
      logic [RW-1:0] rem_in;
      logic [RW-1:0] rem_ff;
      logic [DW-1:0] den_ff;
      logic [QW-1:0] quo_ff;
      logic [PW-1:0] side_ff;
      logic          vld_ff;

      // Compare against the divisor at this bit weight
      assign dsh    = {st_den[gi], {QW{1'b0}}} >> (gi + 1);
      assign ge     = st_rem[gi] >= dsh;
      assign rem_in = ge ? st_rem[gi] - dsh : st_rem[gi];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (adv) begin
            vld_ff <= st_vld[gi];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff  <= rem_in;
            den_ff  <= st_den[gi];
            quo_ff  <= {st_quo[gi][QW-2:0], ge};
            side_ff <= st_side[gi];
         end
      end

      assign st_rem[gi+1]  = rem_ff;
      assign st_den[gi+1]  = den_ff;
      assign st_quo[gi+1]  = quo_ff;
      assign st_side[gi+1] = side_ff;
      assign st_vld[gi+1]  = vld_ff;
   end

   assign out_valid = st_vld[QW];
   assign out_quo   = st_quo[QW];
   assign out_side  = st_side[QW];

endmodule

`default_nettype wire

>>> design/surface_wind_scaling_by_pressure.sv
// Surface wind scaling by pressure: one observation location per beat, one
// factor per beat, one beat accepted every clock unless rsp stalls. Stages in
// order: input register, a 22-stage divider for the 10 m log-pressure height,
// a 4-stage table log unit (three in parallel), difference/region stage,
// multiply stage, round-offset stage, a 16-stage interpolation divider and the
// output register. Backpressure on rsp freezes the whole pipeline in place.
// Depends on swsp_pkg, swsp_log and swsp_div.
`default_nettype none

module surface_wind_scaling_by_pressure #(
   parameter int unsigned LOG_TABLE_BITS = swsp_pkg::LOG_TABLE_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // slave side
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // obs_pressure[16:0], ground_pressure[33:17], lowest_level_pressure[50:34],
   // lowest_level_virtual_temp[65:51], reduction_factor[81:66], zero pad
   input  wire logic [87:0] req_tdata,
   // obs_present[0]
   input  wire logic        req_tuser,
   // master side
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // scaling_factor[15:0]
   output logic      [15:0] rsp_tdata,
   // region[1:0]
   output logic      [1:0]  rsp_tuser,
   // height_log_coefficient write
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);

   localparam int unsigned LAT = swsp_pkg::LOG_LAT;
   localparam int unsigned DX_RW = swsp_pkg::DX_DEN_W + swsp_pkg::DX_QUO_W;
   localparam int unsigned IN_RW = swsp_pkg::INT_DEN_W + swsp_pkg::INT_QUO_W;

   logic adv;
   logic out_vld_ff;

   // Pipeline moves when the output slot is free or being drained
   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   // Configuration register
   logic [15:0] coef_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= swsp_pkg::COEF_RESET;
      end else if (csr_valid) begin
         coef_ff <= csr_data;
      end
   end

   // Input register
   logic        in_vld_ff;
   logic        prs_ff;
   logic [16:0] obs_ff, sfc_ff, low_ff;
   logic [14:0] tv_ff;
   logic [15:0] fq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (adv) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prs_ff <= req_tuser;
         obs_ff <= req_tdata[16:0];
         sfc_ff <= req_tdata[33:17];
         low_ff <= req_tdata[50:34];
         tv_ff  <= req_tdata[65:51];
         fq_ff  <= req_tdata[81:66];
      end
   end

   // 10 m log-pressure height magnitude: round(coef*64 / tv)
   logic [14:0]      tv_fix;
   logic [DX_RW-1:0] dx_num;
   logic             v1;
   logic [21:0]      dq1;
   logic [67:0]      side1;

   assign tv_fix = (tv_ff == 15'd0) ? 15'd1 : tv_ff;
   assign dx_num = DX_RW'({coef_ff, 6'b0}) + DX_RW'(tv_fix >> 1);

   swsp_div #(
      .DW(swsp_pkg::DX_DEN_W),
      .QW(swsp_pkg::DX_QUO_W),
      .PW(68)
   ) u_dx_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (in_vld_ff),
      .in_num   (dx_num),
      .in_den   (tv_fix),
      .in_side  ({prs_ff, obs_ff, sfc_ff, low_ff, fq_ff}),
      .out_valid(v1),
      .out_quo  (dq1),
      .out_side (side1)
   );

   // Three log units in parallel
   logic [19:0] ln_obs, ln_sfc, ln_low;

   swsp_log #(.TABLE_BITS(LOG_TABLE_BITS)) u_log_obs (
      .clock(clock), .adv(adv), .x(side1[66:50]), .ln(ln_obs)
   );
   swsp_log #(.TABLE_BITS(LOG_TABLE_BITS)) u_log_sfc (
      .clock(clock), .adv(adv), .x(side1[49:33]), .ln(ln_sfc)
   );
   swsp_log #(.TABLE_BITS(LOG_TABLE_BITS)) u_log_low (
      .clock(clock), .adv(adv), .x(side1[32:16]), .ln(ln_low)
   );

   // Carry valid, present, factor and height alongside the log units
   logic [LAT-1:0] lv_ff;
   logic [38:0]    ls_ff [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         lv_ff <= '0;
      end else if (adv) begin
         lv_ff <= {lv_ff[LAT-2:0], v1};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ls_ff[0] <= {side1[67], side1[15:0], dq1};
         for (int i = 1; i < LAT; i++) begin
            ls_ff[i] <= ls_ff[i-1];
         end
      end
   end

   // Log differences and region decision
   logic signed [20:0]   d_w, r_w;
   logic signed [22:0]   dx10_w;
   logic signed [21:0]   dr_w;
   logic signed [23:0]   span_w;
   swsp_pkg::region_type reg_w;

   assign d_w    = $signed({1'b0, ln_obs}) - $signed({1'b0, ln_sfc});
   assign r_w    = $signed({1'b0, ln_low}) - $signed({1'b0, ln_sfc});
   assign dx10_w = -$signed({1'b0, ls_ff[LAT-1][21:0]});
   assign dr_w   = 22'(d_w) - 22'(r_w);
   assign span_w = 24'(dx10_w) - 24'(r_w);

   always_comb begin
      priority if (!ls_ff[LAT-1][38]) begin
         reg_w = swsp_pkg::REGION_MISSING;
      end else if (d_w <= r_w) begin
         reg_w = swsp_pkg::REGION_ABOVE;
      end else if (23'(d_w) < dx10_w) begin
         reg_w = swsp_pkg::REGION_INTERP;
      end else begin
         reg_w = swsp_pkg::REGION_BELOW;
      end
   end

   logic                 dv_ff;
   swsp_pkg::region_type reg_d_ff;
   logic [15:0]          fq_d_ff;
   logic signed [20:0]   dr_ff;
   logic [19:0]          span_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= 1'b0;
      end else if (adv) begin
         dv_ff <= lv_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         reg_d_ff  <= reg_w;
         fq_d_ff   <= ls_ff[LAT-1][37:22];
         dr_ff     <= dr_w[20:0];
         span_d_ff <= span_w[19:0];
      end
   end

   // Multiply factor deviation by log distance
   logic signed [16:0]   fdev_w;
   logic signed [37:0]   prod_w;
   logic                 mv_ff;
   swsp_pkg::region_type reg_m_ff;
   logic [15:0]          fq_m_ff;
   logic [19:0]          span_m_ff;
   logic signed [37:0]   prod_ff;

   assign fdev_w = $signed({1'b0, fq_d_ff}) - $signed({1'b0, swsp_pkg::ONE_Q14});
   assign prod_w = 38'(fdev_w) * 38'(dr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= 1'b0;
      end else if (adv) begin
         mv_ff <= dv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         reg_m_ff  <= reg_d_ff;
         fq_m_ff   <= fq_d_ff;
         span_m_ff <= span_d_ff;
         prod_ff   <= prod_w;
      end
   end

   // Magnitude plus half divisor for round to nearest
   logic [37:0]          mag_w;
   logic                 av_ff;
   swsp_pkg::region_type reg_a_ff;
   logic [15:0]          fq_a_ff;
   logic [19:0]          span_a_ff;
   logic [IN_RW-1:0]     num_a_ff;

   assign mag_w = prod_ff[37] ? 38'(-prod_ff) : 38'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         av_ff <= 1'b0;
      end else if (adv) begin
         av_ff <= mv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         reg_a_ff  <= reg_m_ff;
         fq_a_ff   <= fq_m_ff;
         span_a_ff <= span_m_ff;
         num_a_ff  <= mag_w[IN_RW-1:0] + IN_RW'(span_m_ff >> 1);
      end
   end

   // Interpolation quotient
   logic        v2;
   logic [15:0] q2;
   logic [18:0] side2;

   swsp_div #(
      .DW(swsp_pkg::INT_DEN_W),
      .QW(swsp_pkg::INT_QUO_W),
      .PW(19)
   ) u_int_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (av_ff),
      .in_num   (num_a_ff),
      .in_den   (span_a_ff),
      .in_side  ({reg_a_ff, (fq_a_ff < swsp_pkg::ONE_Q14), fq_a_ff}),
      .out_valid(v2),
      .out_quo  (q2),
      .out_side (side2)
   );

   // Select, saturate and register the result
   swsp_pkg::region_type reg_o;
   logic signed [17:0]   res_w;
   logic [15:0]          sat_w;
   logic [15:0]          sf_ff;
   logic [1:0]           rg_ff;

   assign reg_o = swsp_pkg::region_type'(side2[18:17]);

   always_comb begin
      unique case (reg_o)
         swsp_pkg::REGION_MISSING,
         swsp_pkg::REGION_ABOVE:  res_w = 18'sd16384;
         swsp_pkg::REGION_INTERP: res_w = side2[16] ? 18'sd16384 - $signed({2'b0, q2})
                                                    : 18'sd16384 + $signed({2'b0, q2});
         swsp_pkg::REGION_BELOW:  res_w = $signed({2'b0, side2[15:0]});
         default:                 res_w = 18'sd16384;
      endcase
   end

   always_comb begin
      priority if (res_w < 18'sd0) begin
         sat_w = 16'd0;
      end else if (res_w > 18'sd65535) begin
         sat_w = 16'hFFFF;
      end else begin
         sat_w = res_w[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= v2;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sf_ff <= sat_w;
         rg_ff <= reg_o;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = sf_ff;
   assign rsp_tuser  = rg_ff;

endmodule

`default_nettype wire

>>> design/swsp_check.sv
// Port-level checks on the result channel of the wind scaling block,
// bound to the top level. Uses swsp_pkg region codes.
`default_nettype none

module swsp_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // Hold a stalled beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // Drop valid right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // Missing observation gives unity
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == swsp_pkg::REGION_MISSING |-> rsp_tdata == swsp_pkg::ONE_Q14)
      else $error("missing observation not unity");

   // Above lowest level gives unity
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == swsp_pkg::REGION_ABOVE |-> rsp_tdata == swsp_pkg::ONE_Q14)
      else $error("above lowest level not unity");

endmodule

bind surface_wind_scaling_by_pressure swsp_check u_swsp_check (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);

`default_nettype wire

>>> tb/surface_wind_scaling_by_pressure_test.sv
// Self-checking testbench for surface_wind_scaling_by_pressure: drives random and
// corner-case locations, predicts each scaling factor and region, checks every beat.
// Depends on swsp_pkg and the block's RTL.
`timescale 1ns / 100ps

module surface_wind_scaling_by_pressure_test;

   localparam int TBITS = 10;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   typedef struct packed {
      logic [15:0]          factor;
      swsp_pkg::region_type region;
   } wind_result_type;

   wind_result_type expected_factors[$];
   logic [15:0]     ln_frac[1 << TBITS];
   logic [15:0]     height_coef;
   int              fail_count;
   int              send_gap_pct;
   int              recv_stall_pct;

   surface_wind_scaling_by_pressure #(.LOG_TABLE_BITS(TBITS)) DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("** surface_wind_scaling_by_pressure: FAILED **");
      $finish;
   end

   // Fill the fractional log table: ln(1 + i/2^B) in Q16 via atanh series
   function automatic void fill_ln_table();
      longint unsigned den, z, z2, term, sum;
      for (int i = 0; i < (1 << TBITS); i++) begin
         den  = (64'd2 << TBITS) + i;
         z    = (longint'(i) << 32) / den;
         z2   = (z * z) >> 32;
         term = z;
         sum  = 0;
         for (int k = 0; k < 24; k++) begin
            sum  += term / (2 * k + 1);
            term = (term * z2) >> 32;
         end
         ln_frac[i] = 16'((2 * sum + 32768) >> 16);
      end
   endfunction

   function automatic longint ln_pascal(input logic [16:0] p);
      longint unsigned x, frac, idx;
      int e;
      x = (p == 0) ? 1 : p;
      e = 0;
      while ((x >> (e + 1)) != 0) e++;
      frac = x - (64'd1 << e);
      if (e >= TBITS) idx = frac >> (e - TBITS);
      else idx = frac << (TBITS - e);
      idx &= (1 << TBITS) - 1;
      return longint'(e) * swsp_pkg::LN2_Q16 + ln_frac[idx];
   endfunction

   function automatic wind_result_type predict_scaling(input logic present,
                                                       input logic [87:0] d);
      wind_result_type res;
      longint lsfc, dd, rr, dx10, span, num, mag, q, val;
      longint unsigned tv;
      if (!present) begin
         res.factor = swsp_pkg::ONE_Q14;
         res.region = swsp_pkg::REGION_MISSING;
         return res;
      end
      tv   = (d[65:51] == 0) ? 1 : d[65:51];
      lsfc = ln_pascal(d[33:17]);
      dd   = ln_pascal(d[16:0]) - lsfc;
      rr   = ln_pascal(d[50:34]) - lsfc;
      if (dd <= rr) begin
         val = swsp_pkg::ONE_Q14;
         res.region = swsp_pkg::REGION_ABOVE;
      end else begin
         dx10 = -longint'((longint'(height_coef) * 64 + tv / 2) / tv);
         if (dd < dx10) begin
            span = dx10 - rr;
            num  = (longint'(d[81:66]) - swsp_pkg::ONE_Q14) * (dd - rr);
            mag  = num < 0 ? -num : num;
            q    = (mag + span / 2) / span;
            val  = swsp_pkg::ONE_Q14 + (num < 0 ? -q : q);
            res.region = swsp_pkg::REGION_INTERP;
         end else begin
            val = d[81:66];
            res.region = swsp_pkg::REGION_BELOW;
         end
      end
      if (val < 0) val = 0;
      if (val > 65535) val = 65535;
      res.factor = 16'(val);
      return res;
   endfunction

   // Check each result beat against the oldest expectation; stall at random
   always @(posedge clock) begin
      wind_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_factors.size() == 0) begin
            $error("unexpected result beat: scaling_factor %0d region %0d",
                   rsp_tdata, rsp_tuser);
            fail_count++;
         end else begin
            want = expected_factors.pop_front();
            if (rsp_tdata !== want.factor) begin
               $error("scaling_factor: expected %0d, got %0d", want.factor, rsp_tdata);
               fail_count++;
            end
            if (rsp_tuser !== want.region) begin
               $error("region: expected %0d, got %0d", want.region, rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   // Send one location beat, idling first as the sender pace asks; valid
   // stays up on return so the next beat can follow without a gap
   task automatic send_location(input logic present, input logic [16:0] p_obs,
                                input logic [16:0] p_sfc, input logic [16:0] p_low,
                                input logic [14:0] tv, input logic [15:0] fq);
      logic [87:0] data;
      data = {6'd0, fq, tv, p_low, p_sfc, p_obs};
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= present;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_factors.push_back(predict_scaling(present, data));
      @(negedge clock);
   endtask

   // Drop the request valid, wait for the pipeline to drain, then write the
   // height coefficient
   task automatic write_height_coef(input logic [15:0] value);
      req_tvalid <= 1'b0;
      while (expected_factors.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      height_coef = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed: surface above low level, obs near ground; else random
   task automatic send_random_location();
      logic [16:0] ps, pl, po;
      int sel;
      sel = $urandom_range(99);
      ps = 17'($urandom_range(131071, 50000));
      pl = ps - 17'($urandom_range(3000, 100));
      po = pl + 17'($urandom_range(3200, 0));
      if (sel < 15) begin
         ps = 17'($urandom);
         pl = 17'($urandom);
         po = 17'($urandom);
      end
      send_location(sel % 23 != 0, po, ps, pl,
                    sel < 5 ? 15'($urandom) : 15'($urandom_range(20000, 14000)),
                    16'($urandom));
   endtask

   task automatic test_directed();
      send_location(1'b0, 17'h1ffff, 17'h1ffff, 17'h1ffff, 15'h7fff, 16'hffff);
      send_location(1'b1, 0, 0, 0, 0, 0);
      send_location(1'b1, 17'h1ffff, 1, 1, 1, 16'hffff);
      send_location(1'b1, 1, 17'h1ffff, 17'h1ffff, 15'h7fff, 0);
      send_location(1'b1, 100000, 100000, 99000, 18000, 16'd12000);
      send_location(1'b1, 99990, 100000, 99000, 18000, 16'd12000);
      send_location(1'b1, 99500, 100000, 99000, 18000, 16'hffff);
      send_location(1'b1, 99500, 100000, 99000, 18000, 16'd0);
      send_location(1'b1, 99000, 100000, 99000, 18000, 16'd8000);
      send_location(1'b1, 99999, 100000, 99998, 15'h7fff, 16'd100);
      send_location(1'b1, 131071, 131071, 1, 1, 16'd20000);
   endtask

   task automatic test_random(input int count);
      for (int n = 0; n < count; n++) send_random_location();
   endtask

   task automatic test_coefficient_sweep();
      write_height_coef(16'd0);
      test_directed();
      test_random(80);
      write_height_coef(16'hffff);
      test_directed();
      test_random(80);
      write_height_coef(16'($urandom));
      test_random(80);
      write_height_coef(swsp_pkg::COEF_RESET);
   endtask

   initial begin
      fill_ln_table();
      fail_count = 0;
      height_coef = swsp_pkg::COEF_RESET;
      send_gap_pct = 9;
      recv_stall_pct = 86;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_random(550);
      send_gap_pct = 86;
      recv_stall_pct = 9;
      test_coefficient_sweep();
      test_random(550);
      send_gap_pct = 0;
      recv_stall_pct = 0;
      test_random(600);

      req_tvalid <= 1'b0;
      while (expected_factors.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (fail_count == 0)
         $display("** surface_wind_scaling_by_pressure: PASSED **");
      else
         $display("** surface_wind_scaling_by_pressure: FAILED **");
      $finish;
   end
endmodule

>>> filelist.f
design/swsp_pkg.sv
design/swsp_log.sv
design/swsp_div.sv
design/surface_wind_scaling_by_pressure.sv
design/swsp_check.sv
tb/surface_wind_scaling_by_pressure_test.sv
